>>> rtl/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and codes for the sparse polynomial subtract block.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int unsigned MaxTerms = 16;
  localparam int unsigned CntW     = $clog2(MaxTerms + 1);
  localparam int unsigned IdxW     = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;
  localparam int unsigned TotW     = 6;
  localparam int unsigned CoefW    = 32;
  localparam int unsigned ExpW     = 16;

  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [ExpW-1:0]  exp_t;
  typedef logic [CntW-1:0]         cnt_t;
  typedef logic [IdxW-1:0]         idx_t;
  typedef logic [TotW-1:0]         tot_t;

  // input kinds
  localparam logic [1:0] KindLoadMin = 2'd0;
  localparam logic [1:0] KindLoadSub = 2'd1;
  localparam logic [1:0] KindRun     = 2'd2;

  // result status codes
  localparam logic [2:0] StatStored   = 3'd0;
  localparam logic [2:0] StatCombined = 3'd1;
  localparam logic [2:0] StatRejected = 3'd2;
  localparam logic [2:0] StatFull     = 3'd3;
  localparam logic [2:0] StatTerm     = 3'd4;
  localparam logic [2:0] StatEmpty    = 3'd5;

  typedef struct packed {
    logic push;
    logic combine;
    logic clear;
  } store_cmd_t;

endpackage

>>> rtl/sps_alu.sv
// ----------------------------------------------------------------------------
// sps_alu
// Shared saturating add / subtract unit for Q16.16 coefficients.
// ----------------------------------------------------------------------------
module sps_alu (
  input  sps_pkg::coef_t a_i,
  input  sps_pkg::coef_t b_i,
  input  logic           sub_i,
  output sps_pkg::coef_t y_o
);
  import sps_pkg::*;

  logic signed [CoefW:0] a_ext;
  logic signed [CoefW:0] b_ext;
  logic signed [CoefW:0] sum;

  assign a_ext = {a_i[CoefW-1], a_i};
  assign b_ext = {b_i[CoefW-1], b_i};
  assign sum   = sub_i ? (a_ext - b_ext) : (a_ext + b_ext);

  // clamp when the two top bits disagree
  always_comb begin
    if (sum[CoefW] != sum[CoefW-1]) begin
      y_o = sum[CoefW] ? {1'b1, {(CoefW-1){1'b0}}} : {1'b0, {(CoefW-1){1'b1}}};
    end else begin
      y_o = sum[CoefW-1:0];
    end
  end

endmodule

>>> rtl/sps_store.sv
// ----------------------------------------------------------------------------
// sps_store
// One term store: coefficient and exponent arrays, fill count and a copy
// of the most recent term for order checks and combining.
// ----------------------------------------------------------------------------
module sps_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sps_pkg::store_cmd_t cmd_i,
  input  sps_pkg::coef_t      wr_coef_i,
  input  sps_pkg::exp_t       wr_exp_i,
  input  sps_pkg::idx_t       rd_idx_i,
  output sps_pkg::coef_t      rd_coef_o,
  output sps_pkg::exp_t       rd_exp_o,
  output sps_pkg::cnt_t       count_o,
  output sps_pkg::coef_t      last_coef_o,
  output sps_pkg::exp_t       last_exp_o
);
  import sps_pkg::*;

  coef_t coef_mem [MaxTerms];
  exp_t  exp_mem  [MaxTerms];
  cnt_t  count_q;
  coef_t last_coef_q;
  exp_t  last_exp_q;
  cnt_t  top_idx;

  assign top_idx = count_q - cnt_t'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
    end else if (cmd_i.push) begin
      count_q <= count_q + cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      coef_mem[count_q[IdxW-1:0]] <= wr_coef_i;
      exp_mem[count_q[IdxW-1:0]]  <= wr_exp_i;
      last_coef_q                 <= wr_coef_i;
      last_exp_q                  <= wr_exp_i;
    end else if (cmd_i.combine) begin
      coef_mem[top_idx[IdxW-1:0]] <= wr_coef_i;
      last_coef_q                 <= wr_coef_i;
    end
  end

  assign rd_coef_o   = coef_mem[rd_idx_i];
  assign rd_exp_o    = exp_mem[rd_idx_i];
  assign count_o     = count_q;
  assign last_coef_o = last_coef_q;
  assign last_exp_o  = last_exp_q;

endmodule

>>> rtl/sparse_polynomial_subtract.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_subtract
// Each load item's result is registered in the cycle after it is accepted;
// one load accepted per cycle while idle and the output is taken. A run
// walks both stores twice, one merge step per cycle through the shared
// saturating unit, the emitting pass holding while the output is stalled:
// a counting pass of Na+Nb steps at most, then an emitting pass of as many
// steps. Reset empties both stores but does not clear the term arrays.
// ----------------------------------------------------------------------------
module sparse_polynomial_subtract (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     kind_i,
  input  sps_pkg::coef_t coefficient_i,
  input  sps_pkg::exp_t  exponent_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [2:0]     status_o,
  output sps_pkg::coef_t result_coefficient_o,
  output sps_pkg::exp_t  result_exponent_o,
  output logic           last_o,
  output sps_pkg::tot_t  term_count_o
);
  import sps_pkg::*;

  typedef enum logic [1:0] {StIdle, StCount, StEmit} state_e;

  state_e     state_q, state_d;
  cnt_t       ra_q, ra_d, rb_q, rb_d;
  tot_t       total_q, total_d, emitted_q, emitted_d;
  logic       out_valid_q, out_valid_d;
  logic [2:0] status_q, status_d;
  coef_t      rcoef_q, rcoef_d;
  exp_t       rexp_q, rexp_d;
  logic       last_q, last_d;
  tot_t       tcount_q, tcount_d;

  store_cmd_t cmd_a, cmd_b;
  coef_t      wr_coef;
  coef_t      ca, cb, lcoef_a, lcoef_b;
  exp_t       ea, eb, lexp_a, lexp_b;
  cnt_t       cnt_a, cnt_b;
  cnt_t       ra_m1, rb_m1;

  coef_t      alu_a, alu_b, alu_y;
  logic       alu_sub;

  logic       free, accept;
  logic       has_a, has_b, take_a, take_b, emit;
  cnt_t       n_sel;
  exp_t       prev_sel;
  coef_t      lcoef_sel;
  exp_t       step_exp;

  assign ra_m1 = ra_q - cnt_t'(1);
  assign rb_m1 = rb_q - cnt_t'(1);

  sps_store u_store_a (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_a),
    .wr_coef_i   (wr_coef),
    .wr_exp_i    (exponent_i),
    .rd_idx_i    (ra_m1[IdxW-1:0]),
    .rd_coef_o   (ca),
    .rd_exp_o    (ea),
    .count_o     (cnt_a),
    .last_coef_o (lcoef_a),
    .last_exp_o  (lexp_a)
  );

  sps_store u_store_b (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_b),
    .wr_coef_i   (wr_coef),
    .wr_exp_i    (exponent_i),
    .rd_idx_i    (rb_m1[IdxW-1:0]),
    .rd_coef_o   (cb),
    .rd_exp_o    (eb),
    .count_o     (cnt_b),
    .last_coef_o (lcoef_b),
    .last_exp_o  (lexp_b)
  );

  sps_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .y_o   (alu_y)
  );

  assign free       = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && free;
  assign accept     = in_valid_i && in_ready_o;

  assign n_sel     = kind_i[0] ? cnt_b : cnt_a;
  assign prev_sel  = kind_i[0] ? lexp_b : lexp_a;
  assign lcoef_sel = kind_i[0] ? lcoef_b : lcoef_a;

  // merge step decision, highest exponent first
  assign has_a    = (ra_q != '0);
  assign has_b    = (rb_q != '0);
  assign take_a   = !has_b || (has_a && (ea > eb));
  assign take_b   = !take_a && (!has_a || (ea < eb));
  assign emit     = take_a || take_b || (alu_y != '0);
  assign step_exp = take_b ? eb : ea;

  always_comb begin
    if (state_q == StIdle) begin
      alu_a   = lcoef_sel;
      alu_b   = coefficient_i;
      alu_sub = 1'b0;
    end else if (take_a) begin
      alu_a   = ca;
      alu_b   = '0;
      alu_sub = 1'b0;
    end else if (take_b) begin
      alu_a   = '0;
      alu_b   = cb;
      alu_sub = 1'b1;
    end else begin
      alu_a   = ca;
      alu_b   = cb;
      alu_sub = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    total_d     = total_q;
    emitted_d   = emitted_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    rcoef_d     = rcoef_q;
    rexp_d      = rexp_q;
    last_d      = last_q;
    tcount_d    = tcount_q;
    cmd_a       = '0;
    cmd_b       = '0;
    wr_coef     = coefficient_i;

    case (state_q)
      StIdle: begin
        if (accept && (kind_i == KindLoadMin || kind_i == KindLoadSub)) begin
          out_valid_d = 1'b1;
          last_d      = 1'b1;
          tcount_d    = tot_t'(n_sel);
          if (n_sel != '0 && exponent_i < prev_sel) begin
            status_d = StatRejected;
            rcoef_d  = '0;
            rexp_d   = prev_sel;
          end else if (n_sel != '0 && exponent_i == prev_sel) begin
            status_d = StatCombined;
            rcoef_d  = alu_y;
            rexp_d   = exponent_i;
            wr_coef  = alu_y;
            cmd_a.combine = !kind_i[0];
            cmd_b.combine = kind_i[0];
          end else if (n_sel >= cnt_t'(MaxTerms)) begin
            status_d = StatFull;
            rcoef_d  = '0;
            rexp_d   = '0;
          end else begin
            status_d   = StatStored;
            rcoef_d    = coefficient_i;
            rexp_d     = exponent_i;
            tcount_d   = tot_t'(n_sel) + tot_t'(1);
            cmd_a.push = !kind_i[0];
            cmd_b.push = kind_i[0];
          end
        end else if (accept && kind_i == KindRun) begin
          ra_d      = cnt_a;
          rb_d      = cnt_b;
          total_d   = '0;
          emitted_d = '0;
          state_d   = StCount;
        end
      end

      StCount: begin
        if (has_a || has_b) begin
          if (!take_b) ra_d = ra_m1;
          if (!take_a) rb_d = rb_m1;
          if (emit) total_d = total_q + tot_t'(1);
        end else begin
          // rewind for the emitting pass
          ra_d    = cnt_a;
          rb_d    = cnt_b;
          state_d = StEmit;
        end
      end

      StEmit: begin
        if (free) begin
          if (has_a || has_b) begin
            if (!take_b) ra_d = ra_m1;
            if (!take_a) rb_d = rb_m1;
            if (emit) begin
              out_valid_d = 1'b1;
              status_d    = StatTerm;
              rcoef_d     = alu_y;
              rexp_d      = step_exp;
              last_d      = (emitted_q + tot_t'(1) == total_q);
              tcount_d    = total_q;
              emitted_d   = emitted_q + tot_t'(1);
            end
          end else begin
            if (total_q == '0) begin
              out_valid_d = 1'b1;
              status_d    = StatEmpty;
              rcoef_d     = '0;
              rexp_d      = '0;
              last_d      = 1'b1;
              tcount_d    = '0;
            end
            cmd_a.clear = 1'b1;
            cmd_b.clear = 1'b1;
            state_d     = StIdle;
          end
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ra_q        <= '0;
      rb_q        <= '0;
      total_q     <= '0;
      emitted_q   <= '0;
      out_valid_q <= 1'b0;
      status_q    <= '0;
      rcoef_q     <= '0;
      rexp_q      <= '0;
      last_q      <= 1'b0;
      tcount_q    <= '0;
    end else begin
      state_q     <= state_d;
      ra_q        <= ra_d;
      rb_q        <= rb_d;
      total_q     <= total_d;
      emitted_q   <= emitted_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      rcoef_q     <= rcoef_d;
      rexp_q      <= rexp_d;
      last_q      <= last_d;
      tcount_q    <= tcount_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = status_q;
  assign result_coefficient_o = rcoef_q;
  assign result_exponent_o    = rexp_q;
  assign last_o               = last_q;
  assign term_count_o         = tcount_q;

endmodule
